// ----- rtl/core/oukt_pkg.sv -----
// Package for the ordered unique key table: sizes, operation codes and status codes.
// No dependencies; the top level and its sequencer import it.
package oukt_pkg;

    // Table sizing
    localparam int ENTRIES   = 256;
    localparam int KEY_WIDTH = 32;

    // Fixed field widths of the request and result ports
    localparam int KIND_W      = 4;
    localparam int KEY_IN_W    = 32;
    localparam int POS_W       = 9;
    localparam int STATUS_W    = 3;
    localparam int FPOS_W      = 8;
    localparam int COUNT_OUT_W = 9;

    // Derived widths
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int STORE_W = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes
    localparam logic [KIND_W-1:0] K_LOOKUP      = 4'd0;
    localparam logic [KIND_W-1:0] K_APPEND      = 4'd1;
    localparam logic [KIND_W-1:0] K_REMOVE_LAST = 4'd2;
    localparam logic [KIND_W-1:0] K_INSERT_AT   = 4'd3;
    localparam logic [KIND_W-1:0] K_ERASE_KEY   = 4'd4;
    localparam logic [KIND_W-1:0] K_ERASE_AT    = 4'd5;
    localparam logic [KIND_W-1:0] K_REPLACE_KEY = 4'd6;
    localparam logic [KIND_W-1:0] K_REPLACE_AT  = 4'd7;
    localparam logic [KIND_W-1:0] K_CLEAR       = 4'd8;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

// ----- rtl/core/oukt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module oukt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ordered_unique_key_table_top.sv -----
// Top level of the ordered unique key table: request/result channels and the sequencer.
// Depends on oukt_pkg and oukt_ram (key store).
//
// Usage
//   Request channel: i_valid with i_kind, i_key, i_new_key, i_position; the
//   block drives o_stall. A request is taken on a rising edge with i_valid
//   high and o_stall low. Result channel: o_valid with o_status, o_found,
//   o_found_position, o_count; the receiver drives i_stall and a result is
//   taken on an edge with o_valid high and i_stall low.
//   The block works on one request at a time and holds o_stall high until
//   the request's result has moved into the output register. All searching
//   and shifting goes through the single read and single write port of the
//   key store, one entry per cycle. From the accepting edge, remove last,
//   clear, range errors and unused codes go straight to the finish state;
//   lookup, append and replace at search the list; insert at searches for
//   the key, then shifts the later entries up; erase by key searches, then
//   shifts the later entries down, and erase at shifts them down without a
//   search; replace key runs two searches.
//   A finished result waits in the output register while i_stall is high;
//   the next request is then accepted, and its result is held back in the
//   sequencer until the output register frees up.
//   Reset (synchronous, active low) clears the count and drops any result.
module ordered_unique_key_table_top
    import oukt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [KEY_IN_W-1:0]    i_key,
    input  logic [KEY_IN_W-1:0]    i_new_key,
    input  logic [POS_W-1:0]       i_position,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [STATUS_W-1:0]    o_status,
    output logic                   o_found,
    output logic [FPOS_W-1:0]      o_found_position,
    output logic [COUNT_OUT_W-1:0] o_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_FINISH
    } t_state;

    t_state               r_state;
    logic [KIND_W-1:0]    r_kind;
    logic [STORE_W-1:0]   r_key;        // search target, also the key to write
    logic [STORE_W-1:0]   r_new_key;
    logic [CNT_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_idx;        // walk index
    logic [IDX_W-1:0]     r_cmp_idx;    // index of the entry now on the read data
    logic                 r_rd_pend;    // read data valid for r_cmp_idx
    logic                 r_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic                 r_phase2;     // replace key: second search on the new key
    logic [STATUS_W-1:0]  r_status;
    logic                 r_found;
    logic [IDX_W-1:0]     r_fpos;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic                   r_out_found;
    logic [FPOS_W-1:0]      r_out_fpos;
    logic [COUNT_OUT_W-1:0] r_out_count;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_decide_we;
    logic [CNT_W-1:0]     w_idx_dec;
    logic [IDX_W-1:0]     w_cmp_dec;
    logic [CMP_W-1:0]     w_pos_ext;
    logic [CMP_W-1:0]     w_cnt_ext;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [STORE_W-1:0]   w_wdata;
    logic [IDX_W-1:0]     w_raddr;
    logic [STORE_W-1:0]   w_rdata;
    logic                 w_out_free;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_full     = (r_count == CNT_W'(ENTRIES));
    assign w_idx_dec  = r_idx - CNT_W'(1);
    assign w_cmp_dec  = r_cmp_idx - IDX_W'(1);
    assign w_pos_ext  = CMP_W'(i_position);
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_out_free = !r_out_valid || !i_stall;

    // Direct writes decided after a search: append at the end, or replace in place
    always_comb begin
        w_decide_we = 1'b0;
        case (r_kind)
            K_APPEND:      w_decide_we = !r_hit && !w_full;
            K_REPLACE_KEY: w_decide_we = r_phase2 && !r_hit;
            K_REPLACE_AT:  w_decide_we = !r_hit;
            default:       w_decide_we = 1'b0;
        endcase
    end

    // Key store port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos[IDX_W-1:0];
        w_wdata = r_key;
        w_raddr = r_idx[IDX_W-1:0];
        case (r_state)
            S_DECIDE: begin
                w_we = w_decide_we;
            end
            S_SHIFT_UP: begin
                // read the entry below, write it one place up in the next cycle
                w_raddr = w_idx_dec[IDX_W-1:0];
                if (r_rd_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_cmp_idx;
                    w_wdata = w_rdata;
                end else if (r_idx <= r_pos) begin
                    w_we = 1'b1;
                end
            end
            S_SHIFT_DOWN: begin
                if (r_rd_pend) begin
                    w_we    = 1'b1;
                    w_waddr = w_cmp_dec;
                    w_wdata = w_rdata;
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    oukt_ram #(
        .WIDTH (STORE_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the delivered result unless a new one takes its place
            if (r_out_valid && !i_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind    <= i_kind;
                        r_key     <= i_key[STORE_W-1:0];
                        r_new_key <= i_new_key[STORE_W-1:0];
                        r_pos     <= CNT_W'(i_position);
                        r_idx     <= '0;
                        r_rd_pend <= 1'b0;
                        r_phase2  <= 1'b0;
                        r_status  <= ST_DONE;
                        r_found   <= 1'b0;
                        r_fpos    <= '0;
                        case (i_kind)
                            K_LOOKUP, K_ERASE_KEY, K_REPLACE_KEY: begin
                                r_state <= S_SEARCH;
                            end
                            K_APPEND: begin
                                r_pos   <= r_count;
                                r_state <= S_SEARCH;
                            end
                            K_REMOVE_LAST: begin
                                if (r_count == '0) begin
                                    r_status <= ST_RANGE;
                                end else begin
                                    r_count <= r_count - CNT_W'(1);
                                end
                                r_state <= S_FINISH;
                            end
                            K_INSERT_AT: begin
                                if (w_pos_ext > w_cnt_ext) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_FINISH;
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            K_ERASE_AT: begin
                                if (w_pos_ext >= w_cnt_ext) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_FINISH;
                                end else begin
                                    r_idx   <= CNT_W'(i_position) + CNT_W'(1);
                                    r_state <= S_SHIFT_DOWN;
                                end
                            end
                            K_REPLACE_AT: begin
                                r_key <= i_new_key[STORE_W-1:0];
                                if (w_pos_ext >= w_cnt_ext) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_FINISH;
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            K_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_FINISH;
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end

                S_SEARCH: begin
                    // compare the entry read last cycle, issue the next read
                    if (r_rd_pend && (w_rdata == r_key)) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                        r_rd_pend <= 1'b0;
                        r_state   <= S_DECIDE;
                    end else if (r_idx < r_count) begin
                        r_rd_pend <= 1'b1;
                        r_cmp_idx <= r_idx[IDX_W-1:0];
                        r_idx     <= r_idx + CNT_W'(1);
                    end else if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                    end else begin
                        r_hit   <= 1'b0;
                        r_state <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    r_state <= S_FINISH;
                    case (r_kind)
                        K_LOOKUP: begin
                            if (r_hit) begin
                                r_found <= 1'b1;
                                r_fpos  <= r_hit_idx;
                            end else begin
                                r_status <= ST_NOT_FOUND;
                            end
                        end
                        K_APPEND: begin
                            if (r_hit) begin
                                r_status <= ST_PRESENT;
                            end else if (w_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                        K_INSERT_AT: begin
                            if (r_hit) begin
                                r_status <= ST_PRESENT;
                            end else if (w_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_idx   <= r_count;
                                r_state <= S_SHIFT_UP;
                            end
                        end
                        K_ERASE_KEY: begin
                            if (r_hit) begin
                                r_idx   <= CNT_W'(r_hit_idx) + CNT_W'(1);
                                r_state <= S_SHIFT_DOWN;
                            end else begin
                                r_status <= ST_NOT_FOUND;
                            end
                        end
                        K_REPLACE_KEY: begin
                            if (!r_phase2) begin
                                if (r_hit) begin
                                    // search again, now for the new key
                                    r_pos    <= CNT_W'(r_hit_idx);
                                    r_key    <= r_new_key;
                                    r_phase2 <= 1'b1;
                                    r_idx    <= '0;
                                    r_state  <= S_SEARCH;
                                end else begin
                                    r_status <= ST_NOT_FOUND;
                                end
                            end else if (r_hit) begin
                                r_status <= ST_PRESENT;
                            end
                        end
                        K_REPLACE_AT: begin
                            if (r_hit) begin
                                r_status <= ST_PRESENT;
                            end
                        end
                        default: begin
                            r_status <= ST_DONE;
                        end
                    endcase
                end

                S_SHIFT_UP: begin
                    if (r_idx > r_pos) begin
                        r_rd_pend <= 1'b1;
                        r_cmp_idx <= r_idx[IDX_W-1:0];
                        r_idx     <= w_idx_dec;
                    end else if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                    end else begin
                        // new key lands at the freed position this cycle
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_FINISH;
                    end
                end

                S_SHIFT_DOWN: begin
                    if (r_idx < r_count) begin
                        r_rd_pend <= 1'b1;
                        r_cmp_idx <= r_idx[IDX_W-1:0];
                        r_idx     <= r_idx + CNT_W'(1);
                    end else if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_FINISH;
                    end
                end

                S_FINISH: begin
                    // hold the result until the output register is free
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_found  <= r_found;
                        r_out_fpos   <= FPOS_W'(r_fpos);
                        r_out_count  <= COUNT_OUT_W'(r_count);
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found          = r_out_found;
    assign o_found_position = r_out_fpos;
    assign o_count          = r_out_count;

    // The count never passes the table size
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    // The key store is never written while waiting for a request
    a_no_idle_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("key store written while idle");

    // The count moves by at most one entry, except for a clear
    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CNT_W'(1)) ||
            (r_count == $past(r_count) - CNT_W'(1)) ||
            (r_count == '0))
        else $error("entry count jumped");

    // A found flag only comes with a successful status
    a_found_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == ST_DONE))
        else $error("found flag with failing status");

    // A taken request blocks the channel on the next cycle
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("request channel open right after accept");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for ordered_unique_key_table_top: directed, full-table,
// back-pressure and random request tests against an in-bench table predictor.
// Depends on oukt_pkg and the RTL of ordered_unique_key_table_top.
module tb_top
    import oukt_pkg::*;
();

    // Key bits that the table keeps; wider request keys are cut down to these.
    localparam logic [KEY_IN_W-1:0] KEY_MASK = {KEY_IN_W{1'b1}} >> (KEY_IN_W - STORE_W);
    localparam int POOL_SIZE      = 64;
    localparam int DRAIN_CYCLES   = 2 * ENTRIES + 100;
    localparam int HOLD_OFF_LEN   = 400;

    // Operation codes outside the defined set
    localparam logic [KIND_W-1:0] K_UNUSED_FIRST = K_CLEAR + KIND_W'(1);
    localparam logic [KIND_W-1:0] K_UNUSED_LAST  = '1;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   found;
        logic [FPOS_W-1:0]      fpos;
        logic [COUNT_OUT_W-1:0] count;
    } t_table_result;

    // Ports of the block; every input starts at a known value.
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_valid    = 1'b0;
    logic                   o_stall;
    logic [KIND_W-1:0]      i_kind     = '0;
    logic [KEY_IN_W-1:0]    i_key      = '0;
    logic [KEY_IN_W-1:0]    i_new_key  = '0;
    logic [POS_W-1:0]       i_position = '0;
    logic                   o_valid;
    logic                   i_stall    = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic                   o_found;
    logic [FPOS_W-1:0]      o_found_position;
    logic [COUNT_OUT_W-1:0] o_count;

    // Predictor copy of the table, advanced once per accepted request.
    logic [KEY_IN_W-1:0] table_keys [ENTRIES];
    int                  table_count = 0;
    t_table_result       pending_results [$];

    logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];
    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    int  hold_off_cycles = 0;
    logic hold_on        = 1'b0;
    int  mismatches      = 0;
    int  results_seen    = 0;

    ordered_unique_key_table_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_key            (i_key),
        .i_new_key        (i_new_key),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_count          (o_count)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Table predictor
    // ---------------------------------------------------------------------

    // Search from position 0 upward over the live entries only.
    function automatic bit find_key(input logic [KEY_IN_W-1:0] k, output int at);
        at = 0;
        for (int i = 0; i < table_count; i++) begin
            if (table_keys[i] == k) begin
                at = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Open a slot at p by moving later entries up, then store k there.
    function automatic void put_key(input int p, input logic [KEY_IN_W-1:0] k);
        for (int i = table_count; i > p; i--) begin
            table_keys[i] = table_keys[i-1];
        end
        table_keys[p] = k;
        table_count++;
    endfunction

    // Close the slot at p by moving later entries down.
    function automatic void drop_key(input int p);
        for (int i = p; i + 1 < table_count; i++) begin
            table_keys[i] = table_keys[i+1];
        end
        table_count--;
    endfunction

    // Apply one request to the predictor table and return the result it yields.
    function automatic t_table_result table_op_result(
        input logic [KIND_W-1:0]   kind,
        input logic [KEY_IN_W-1:0] key,
        input logic [KEY_IN_W-1:0] new_key,
        input logic [POS_W-1:0]    position
    );
        t_table_result       res;
        logic [KEY_IN_W-1:0] k;
        logic [KEY_IN_W-1:0] nk;
        int                  p;
        int                  at;
        int                  other;
        res = '0;
        k   = key & KEY_MASK;
        nk  = new_key & KEY_MASK;
        p   = int'(position);
        case (kind)
            K_LOOKUP: begin
                if (find_key(k, at)) begin
                    res.found = 1'b1;
                    res.fpos  = at[FPOS_W-1:0];
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            K_APPEND: begin
                if (find_key(k, at))              res.status = ST_PRESENT;
                else if (table_count >= ENTRIES)  res.status = ST_FULL;
                else                              put_key(table_count, k);
            end
            K_REMOVE_LAST: begin
                if (table_count == 0) res.status = ST_RANGE;
                else                  table_count--;
            end
            K_INSERT_AT: begin
                // Range first, then presence, then fullness.
                if (p > table_count)              res.status = ST_RANGE;
                else if (find_key(k, at))         res.status = ST_PRESENT;
                else if (table_count >= ENTRIES)  res.status = ST_FULL;
                else                              put_key(p, k);
            end
            K_ERASE_KEY: begin
                if (find_key(k, at)) drop_key(at);
                else                 res.status = ST_NOT_FOUND;
            end
            K_ERASE_AT: begin
                if (p >= table_count) res.status = ST_RANGE;
                else                  drop_key(p);
            end
            K_REPLACE_KEY: begin
                // The old key must exist before the new key is looked at.
                if (!find_key(k, at))           res.status = ST_NOT_FOUND;
                else if (find_key(nk, other))   res.status = ST_PRESENT;
                else                            table_keys[at] = nk;
            end
            K_REPLACE_AT: begin
                if (p >= table_count)         res.status = ST_RANGE;
                else if (find_key(nk, at))    res.status = ST_PRESENT;
                else                          table_keys[p] = nk;
            end
            K_CLEAR: begin
                table_count = 0;
            end
            default: begin
                // Unused codes leave the table alone and report done.
            end
        endcase
        res.count = table_count[COUNT_OUT_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Valid stays high
    // on return so back-to-back requests need no second assignment per step.
    task automatic send_request(
        input logic [KIND_W-1:0]   kind,
        input logic [KEY_IN_W-1:0] key,
        input logic [KEY_IN_W-1:0] new_key,
        input logic [POS_W-1:0]    position
    );
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        i_new_key  <= new_key;
        i_position <= position;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // Taken at this edge: advance the predictor in request order.
        pending_results.insert(pending_results.size(),
                               table_op_result(kind, key, new_key, position));
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s mismatch, got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // Stall at random, or solidly while a hold-off is running.
    always @(posedge i_clk) begin
        i_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end

    // Count out a requested hold-off in cycles, independent of the sender.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_on <= 1'b1;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_on <= 1'b0;
                hold_off_cycles = 0;
            end
        end
    end

    // Compare each taken result with the oldest prediction.
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested result, status", o_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_found !== want.found)
                    report_mismatch("found", o_found, want.found);
                if (o_found_position !== want.fpos)
                    report_mismatch("found_position", o_found_position, want.fpos);
                if (o_count !== want.count)
                    report_mismatch("count", o_count, want.count);
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Hit every operation but append and clear on an empty table, plus the unused codes.
    task automatic test_empty_table();
        send_request(K_LOOKUP,      32'h0000_0000, 32'h0, 9'd0);
        send_request(K_REMOVE_LAST, 32'h0000_0000, 32'h0, 9'd0);
        send_request(K_ERASE_KEY,   32'h1234_5678, 32'h0, 9'd0);
        send_request(K_ERASE_AT,    32'h0,         32'h0, 9'd0);
        send_request(K_REPLACE_KEY, 32'h1,         32'h2, 9'd0);
        send_request(K_REPLACE_AT,  32'h0,         32'h2, 9'd0);
        send_request(K_INSERT_AT,   32'h5,         32'h0, 9'd1);
        send_request(K_UNUSED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF);
        send_request(K_UNUSED_LAST,  32'h0,         32'h0, 9'd0);
        wait_drained();
    endtask

    // Field extremes and the ordering of the error checks on a small table.
    task automatic test_basic_ops();
        send_request(K_INSERT_AT,   32'h0000_0000, 32'h0, 9'd0);   // [0]
        send_request(K_APPEND,      32'hFFFF_FFFF, 32'h0, 9'd0);   // [0 F]
        send_request(K_APPEND,      32'h0000_0000, 32'h0, 9'd0);   // already present
        send_request(K_INSERT_AT,   32'hA5A5_A5A5, 32'h0, 9'd1);   // [0 A F]
        send_request(K_INSERT_AT,   32'h5A5A_5A5A, 32'h0, 9'd3);   // at the end
        send_request(K_INSERT_AT,   32'h0000_0000, 32'h0, 9'd5);   // range beats presence
        send_request(K_INSERT_AT,   32'hA5A5_A5A5, 32'h0, 9'd2);   // present
        send_request(K_LOOKUP,      32'h5A5A_5A5A, 32'h0, 9'd0);
        send_request(K_LOOKUP,      32'hFFFF_FFFF, 32'h0, 9'd0);
        send_request(K_REPLACE_KEY, 32'h7777_7777, 32'h0, 9'd0);   // old missing first
        send_request(K_REPLACE_KEY, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 9'd0); // onto itself
        send_request(K_REPLACE_KEY, 32'hA5A5_A5A5, 32'h1111_1111, 9'd0);
        send_request(K_REPLACE_AT,  32'h0,         32'hFFFF_FFFF, 9'd1); // new present
        send_request(K_REPLACE_AT,  32'h0,         32'hFFFF_FFFF, 9'd4); // range first
        send_request(K_REPLACE_AT,  32'h0,         32'h2222_2222, 9'd0);
        send_request(K_ERASE_KEY,   32'h1111_1111, 32'h0, 9'd0);
        send_request(K_ERASE_AT,    32'h0,         32'h0, 9'h1FF);
        send_request(K_ERASE_AT,    32'h0,         32'h0, 9'd0);
        send_request(K_REMOVE_LAST, 32'h0,         32'h0, 9'd0);
        send_request(K_CLEAR,       32'h0,         32'h0, 9'd0);
        wait_drained();
    endtask

    // Fill the table to capacity and probe the full and boundary cases.
    task automatic test_full_table();
        logic [KEY_IN_W-1:0] k;
        for (int i = 0; i < ENTRIES; i++) begin
            k = KEY_IN_W'((i + 1) * 32'h9E37_79B9);
            send_request(K_APPEND, k, 32'h0, 9'd0);
        end
        k = KEY_IN_W'(ENTRIES * 32'h9E37_79B9);
        send_request(K_LOOKUP,    k,             32'h0, 9'd0);        // last position
        send_request(K_APPEND,    32'h0BAD_0BAD, 32'h0, 9'd0);        // full
        send_request(K_APPEND,    k,             32'h0, 9'd0);        // present
        send_request(K_INSERT_AT, 32'h0BAD_0BAD, 32'h0, 9'(ENTRIES)); // full
        send_request(K_INSERT_AT, 32'h0BAD_0BAD, 32'h0, 9'(ENTRIES + 1));
        send_request(K_INSERT_AT, k,             32'h0, 9'd0);        // present
        send_request(K_REPLACE_AT, 32'h0,        32'h0BAD_0BAD, 9'(ENTRIES - 1));
        send_request(K_ERASE_KEY, 32'h9E37_79B9, 32'h0, 9'd0);        // first entry
        send_request(K_INSERT_AT, 32'h0000_0000, 32'h0, 9'(ENTRIES - 1));
        send_request(K_ERASE_AT,  32'h0,         32'h0, 9'(ENTRIES - 1));
        send_request(K_REMOVE_LAST, 32'h0,       32'h0, 9'd0);
        send_request(K_CLEAR,     32'h0,         32'h0, 9'd0);
        wait_drained();
    endtask

    function automatic logic [KEY_IN_W-1:0] pick_key();
        if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom();
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(9);
        if (roll < 7)      return POS_W'($urandom_range(table_count));
        else if (roll < 8) return POS_W'(table_count);
        return POS_W'($urandom_range((1 << POS_W) - 1));
    endfunction

    // Random mix of operations over a small key pool so that hits are common.
    task automatic run_random_items(input int n_items);
        logic [KIND_W-1:0] kind;
        int                roll;
        int                sent;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 20)      kind = K_LOOKUP;
            else if (roll < 40) kind = K_APPEND;
            else if (roll < 46) kind = K_REMOVE_LAST;
            else if (roll < 60) kind = K_INSERT_AT;
            else if (roll < 70) kind = K_ERASE_KEY;
            else if (roll < 78) kind = K_ERASE_AT;
            else if (roll < 86) kind = K_REPLACE_KEY;
            else if (roll < 94) kind = K_REPLACE_AT;
            else if (roll < 96) kind = K_CLEAR;
            else                kind = KIND_W'($urandom_range(K_UNUSED_FIRST, K_UNUSED_LAST));
            // Keep the table moderately sized so the walks stay short.
            if (table_count > 40 && (kind == K_APPEND || kind == K_INSERT_AT)
                    && $urandom_range(1) == 0)
                kind = K_ERASE_AT;
            send_request(kind, pick_key(), pick_key(), pick_position());
            if (kind <= K_CLEAR) sent++;
        end
        wait_drained();
    endtask

    // Stall the result side for a long stretch while requests keep coming,
    // so the block fills its output and holds off the request side.
    task automatic test_backpressure();
        for (int i = 0; i < 8; i++) begin
            send_request(K_APPEND, key_pool[i], 32'h0, 9'd0);
        end
        wait_drained();
        hold_off_cycles = HOLD_OFF_LEN;
        for (int i = 0; i < 12; i++) begin
            send_request(K_LOOKUP, key_pool[$urandom_range(15)], 32'h0, 9'd0);
        end
        wait_drained();
    endtask

    task automatic run_idle_phases();
        run_random_items(140);
        sender_idle_pct = 64;
        run_random_items(140);
        sender_idle_pct = 0;
        recv_stall_pct  = 64;
        run_random_items(140);
        sender_idle_pct = 35;
        recv_stall_pct  = 35;
        run_random_items(140);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

        // Hold reset at the start, then release it once for the whole run.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_basic_ops();
        test_full_table();
        test_backpressure();
        run_idle_phases();

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
